/* rtl/ldrt_pkg.sv */
// Shared constants and helpers for the longest distinct run tracker.
// Stand-alone package; used by the position memory and the top level.
`timescale 1ns / 1ps

package ldrt_pkg;

  // fixed field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned CHAR_VALUES = 1 << CHAR_W;

  // parameter defaults
  localparam int unsigned MAX_LEN_DEF  = 65536;
  localparam int unsigned ALPHABET_DEF = 256;

  // map from character byte to table index
  typedef logic [CHAR_VALUES-1:0][CHAR_W-1:0] char_map_t;

  // character modulo alphabet, built by counting so no divider is needed
  function automatic char_map_t char_map(input int unsigned alpha);
    char_map_t   map;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < CHAR_VALUES; i++) begin
      map[i] = CHAR_W'(r);
      if (r + 1 == alpha) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return map;
  endfunction

endpackage

/* rtl/ldrt_pos_mem.sv */
// Last-seen position memory: one write port, one registered read port.
// Depends on ldrt_pkg for the default depth, ALPHABET_DEF.
`timescale 1ns / 1ps

module ldrt_pos_mem import ldrt_pkg::*; #(
  parameter int unsigned DEPTH = ALPHABET_DEF,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/longest_distinct_run_tracker.sv */
// Longest repeat-free run tracker, top level.
// Depends on ldrt_pkg and ldrt_pos_mem.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_char_in,         | in
//           | in_first_of_string, in_last_of_string   |
//   result  | out_valid, out_stall, out_window_length,| out
//           | out_longest_so_far, out_at_end,         |
//           | out_overflow                            |
//
// One item per cycle while out_stall is low; out_valid rises as the item leaves
// stage one. Memory is read at accept, the item updates state in stage one while
// a forwarding register covers a write to the same entry by the item ahead.
// Synchronous active-low reset clears seen marks and counters at once.
// A stalled result holds the output register; the update stage then waits
// and in_stall rises, so nothing in flight is lost.
`timescale 1ns / 1ps

module longest_distinct_run_tracker import ldrt_pkg::*; #(
  parameter int unsigned MAX_LEN  = MAX_LEN_DEF,
  parameter int unsigned ALPHABET = ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic              in_first_of_string,
  input  logic              in_last_of_string,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  out_window_length,
  output logic [LEN_W-1:0]  out_longest_so_far,
  output logic              out_at_end,
  output logic              out_overflow
);

  localparam int unsigned IDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned POS_W = $clog2(MAX_LEN);
  localparam char_map_t   CHAR_MAP = char_map(ALPHABET);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);

  // pipeline control
  logic             s1_valid_r;
  logic             s1_go;
  logic             in_fire;
  logic             out_valid_r;
  logic             out_free;

  // stage one payload
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic             fwd_hit_r;
  logic [POS_W-1:0] fwd_pos_r;

  // string state
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic                ovf_r, ovf_nxt;
  logic [ALPHABET-1:0] seen_r, seen_nxt;

  // stage one datapath
  logic [POS_W-1:0] rd_pos;
  logic [POS_W-1:0] last_pos;
  logic [CNT_W-1:0] left_eff, cnt_eff, best_eff;
  logic             ovf_eff;
  logic             tracked;
  logic             seen_bit;
  logic [CNT_W-1:0] after;
  logic [CNT_W-1:0] run;
  logic             wr_en;
  logic [POS_W-1:0] wr_pos;
  logic [CNT_W+LEN_W-1:0] run_ext, best_ext;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign in_idx   = CHAR_MAP[in_char_in][IDX_W-1:0];

  ldrt_pos_mem #(
    .DEPTH  (ALPHABET),
    .IDX_W  (IDX_W),
    .DATA_W (POS_W)
  ) u_pos_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .rd_data (rd_pos),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (wr_pos)
  );

  // update stage: string clear, window move, best length, overflow flag
  always_comb begin
    if (s1_first_r) begin
      left_eff = '0;
      cnt_eff  = '0;
      best_eff = '0;
      ovf_eff  = 1'b0;
      seen_bit = 1'b0;
    end else begin
      left_eff = left_r;
      cnt_eff  = cnt_r;
      best_eff = best_r;
      ovf_eff  = ovf_r;
      seen_bit = seen_r[s1_idx_r];
    end
    last_pos = fwd_hit_r ? fwd_pos_r : rd_pos;
    after    = CNT_W'(last_pos) + CNT_W'(1);
    tracked  = cnt_eff < CNT_LIMIT;
    wr_pos   = cnt_eff[POS_W-1:0];
    wr_en    = s1_go && tracked;

    left_nxt = left_eff;
    cnt_nxt  = cnt_eff;
    best_nxt = best_eff;
    ovf_nxt  = ovf_eff;
    seen_nxt = s1_first_r ? '0 : seen_r;

    if (tracked) begin
      if (seen_bit && (after > left_eff)) begin
        left_nxt = after;
      end
      run = cnt_eff - left_nxt + CNT_W'(1);
      if (run > best_eff) begin
        best_nxt = run;
      end
      cnt_nxt = cnt_eff + CNT_W'(1);
      seen_nxt[s1_idx_r] = 1'b1;
    end else begin
      ovf_nxt = 1'b1;
      run     = cnt_eff - left_eff;
    end

    run_ext  = {{LEN_W{1'b0}}, run};
    best_ext = {{LEN_W{1'b0}}, best_nxt};
  end

  // string state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      cnt_r  <= '0;
      best_r <= '0;
      ovf_r  <= 1'b0;
      seen_r <= '0;
    end else if (s1_go) begin
      left_r <= left_nxt;
      cnt_r  <= cnt_nxt;
      best_r <= best_nxt;
      ovf_r  <= ovf_nxt;
      seen_r <= seen_nxt;
    end
  end

  // stage one valid and forwarding control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= wr_en && (s1_idx_r == in_idx);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r   <= in_idx;
      s1_first_r <= in_first_of_string;
      s1_last_r  <= in_last_of_string;
      fwd_pos_r  <= wr_pos;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_window_length  <= run_ext[LEN_W-1:0];
      out_longest_so_far <= best_ext[LEN_W-1:0];
      out_at_end         <= s1_last_r;
      out_overflow       <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* bench/tb_longest_distinct_run_tracker.sv */
// Self-checking bench for longest_distinct_run_tracker: directed and random strings.
// Depends on ldrt_pkg and the tracker RTL; predicts each result item in step with acceptance.
`timescale 1ns / 1ps

module tb_longest_distinct_run_tracker;
  import ldrt_pkg::*;

  localparam int unsigned RUN_LIMIT      = MAX_LEN_DEF;
  localparam int unsigned ALPHA          = ALPHABET_DEF;
  localparam int unsigned RANDOM_ITEMS   = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              str_start;
    logic              str_end;
  } char_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] best_len;
    logic             at_end;
    logic             overflow;
  } run_result_t;

  logic              clk;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_char_in         = '0;
  logic              in_first_of_string = 1'b0;
  logic              in_last_of_string  = 1'b0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [LEN_W-1:0]  out_window_length;
  logic [LEN_W-1:0]  out_longest_so_far;
  logic              out_at_end;
  logic              out_overflow;

  // stimulus and expected result items
  char_item_t  pending_chars[$];
  run_result_t expected_runs[$];
  char_item_t  drive_item;
  run_result_t got_run;
  run_result_t want_run;

  int unsigned total_items   = 0;
  int unsigned offered_count = 0;
  int unsigned taken_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned in_gap        = 0;
  int unsigned in_calm       = 0;
  int unsigned stall_left    = 0;
  int unsigned out_calm      = 0;
  logic        moved;

  // mirrored tracker state
  logic [LEN_W-1:0] last_pos [ALPHA];
  logic [ALPHA-1:0] seen        = '0;
  logic [LEN_W-1:0] win_left    = '0;
  logic [LEN_W-1:0] char_count  = '0;
  logic [LEN_W-1:0] best_len    = '0;
  logic             overflowed  = 1'b0;

  longest_distinct_run_tracker #(
    .MAX_LEN (RUN_LIMIT),
    .ALPHABET(ALPHA)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_first_of_string(in_first_of_string),
    .in_last_of_string (in_last_of_string),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_length (out_window_length),
    .out_longest_so_far(out_longest_so_far),
    .out_at_end        (out_at_end),
    .out_overflow      (out_overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // advance the run tracking by one character, return its result item
  function automatic run_result_t track_char(input char_item_t item);
    run_result_t      res;
    int unsigned      idx;
    logic [LEN_W-1:0] after;
    logic [LEN_W-1:0] run_len;
    idx = item.ch % ALPHA;
    if (item.str_start) begin
      seen       = '0;
      win_left   = '0;
      char_count = '0;
      best_len   = '0;
      overflowed = 1'b0;
    end
    if (char_count >= RUN_LIMIT) begin
      // saturated: state frozen, run of the last tracked character repeats
      overflowed = 1'b1;
      run_len    = char_count - win_left;
    end else begin
      if (seen[idx]) begin
        after = last_pos[idx] + 1'b1;
        if (after > win_left) begin
          win_left = after;
        end
      end
      last_pos[idx] = char_count;
      seen[idx]     = 1'b1;
      run_len       = char_count - win_left + 1'b1;
      if (run_len > best_len) begin
        best_len = run_len;
      end
      char_count = char_count + 1'b1;
    end
    res.window_len = run_len;
    res.best_len   = best_len;
    res.at_end     = item.str_end;
    res.overflow   = overflowed;
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_item(input logic [CHAR_W-1:0] ch, input logic s, input logic e);
    char_item_t item;
    item.ch        = ch;
    item.str_start = s;
    item.str_end   = e;
    pending_chars.push_back(item);
  endtask

  // characters drawn from a window of span values starting at a random base
  task automatic add_string(input int unsigned len, input int unsigned span,
                            input bit with_start, input bit with_end);
    int unsigned base;
    base = $urandom_range(0, CHAR_VALUES - 1);
    for (int unsigned i = 0; i < len; i++) begin
      add_item(CHAR_W'(base + $urandom_range(0, span - 1)), with_start && i == 0,
               with_end && i == len - 1);
    end
  endtask

  // string of all-distinct characters taken from a shuffle
  task automatic add_distinct_run(input int unsigned len, input bit with_end);
    logic [CHAR_W-1:0] perm [CHAR_VALUES];
    logic [CHAR_W-1:0] tmp;
    int unsigned       j;
    for (int i = 0; i < CHAR_VALUES; i++) begin
      perm[i] = CHAR_W'(i);
    end
    for (int i = CHAR_VALUES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int unsigned i = 0; i < len; i++) begin
      add_item(perm[i], i == 0, with_end && i == len - 1);
    end
  endtask

  // input driver, one item per handshake
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || taken_count == offered_count) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_chars.size() > 0) begin
          drive_item = pending_chars.pop_front();
          in_char_in         <= drive_item.ch;
          in_first_of_string <= drive_item.str_start;
          in_last_of_string  <= drive_item.str_end;
          in_valid           <= 1'b1;
          offered_count++;
          if (in_calm > 0) begin
            in_calm--;
          end else begin
            in_gap = idle_len();
            if ($urandom_range(0, 63) == 0) in_calm = $urandom_range(20, 100);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_calm > 0) begin
        out_calm--;
      end else begin
        stall_left = idle_len();
        if ($urandom_range(0, 63) == 0) out_calm = $urandom_range(20, 100);
      end
    end
  end

  // accept tracking, result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        expected_runs.push_back(track_char({in_char_in, in_first_of_string,
                                            in_last_of_string}));
        taken_count++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved   = 1'b1;
        got_run = {out_window_length, out_longest_so_far, out_at_end, out_overflow};
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: no item expected, got window %0d best %0d end %b ovf %b",
                     results_seen, got_run.window_len, got_run.best_len, got_run.at_end,
                     got_run.overflow);
          end
        end else begin
          want_run = expected_runs.pop_front();
          if (got_run.window_len !== want_run.window_len ||
              got_run.best_len !== want_run.best_len ||
              got_run.at_end !== want_run.at_end ||
              got_run.overflow !== want_run.overflow) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: exp window %0d best %0d end %b ovf %b, got %0d %0d %b %b",
                       results_seen, want_run.window_len, want_run.best_len,
                       want_run.at_end, want_run.overflow, got_run.window_len,
                       got_run.best_len, got_run.at_end, got_run.overflow);
            end
          end
        end
        results_seen++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned len;
    int unsigned span;
    int unsigned stop_at;

    // no start flag right after reset behaves as a fresh string
    add_item("a", 1'b0, 1'b0);
    add_item("b", 1'b0, 1'b0);
    add_item("a", 1'b0, 1'b1);
    // item after an end without a start flag continues the string
    add_item("c", 1'b0, 1'b0);
    add_item("b", 1'b0, 1'b1);
    // one-character strings at both byte extremes
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    // extremes with immediate repeat
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    // abcabcbb
    add_item("a", 1'b1, 1'b0);
    add_item("b", 1'b0, 1'b0);
    add_item("c", 1'b0, 1'b0);
    add_item("a", 1'b0, 1'b0);
    add_item("b", 1'b0, 1'b0);
    add_item("c", 1'b0, 1'b0);
    add_item("b", 1'b0, 1'b0);
    add_item("b", 1'b0, 1'b1);
    // new string started before the old one ended
    add_item("p", 1'b1, 1'b0);
    add_item("q", 1'b0, 1'b0);
    add_item("p", 1'b1, 1'b0);
    add_item("q", 1'b0, 1'b1);

    // random strings, mostly well formed, some noise
    stop_at = pending_chars.size() + RANDOM_ITEMS;
    while (pending_chars.size() < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          add_item(CHAR_W'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        end
      end else if (pick < 11) begin
        add_distinct_run($urandom_range(64, CHAR_VALUES), 1'b1);
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120);
        case ($urandom_range(0, 3))
          0: begin
            span = 2;
          end
          1: begin
            span = 5;
          end
          2: begin
            span = 20;
          end
          default: begin
            span = CHAR_VALUES;
          end
        endcase
        add_string(len, span, $urandom_range(0, 99) >= 8, $urandom_range(0, 99) >= 8);
      end
    end

    // continuing a finished string, then a fresh short one
    add_item(8'h41, 1'b0, 1'b1);
    add_item(8'h41, 1'b1, 1'b0);
    add_item(8'h42, 1'b0, 1'b1);
    total_items = pending_chars.size();

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // drain then settle
    while (taken_count != total_items || expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
